[hw/rtl/mdzr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix diagonal zigzag reorder package
// Shared widths, register indexes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mdzr_pkg;

   localparam int VALUE_W   = 32;
   localparam int DIM_W     = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;
      logic step_en;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_done;
      logic emit_last;
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/matrix_diagonal_zigzag_reorder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix diagonal zigzag reorder
// Buffers a row-major matrix and replays it in diagonal zigzag order.
// ----------------------------------------------------------------------------
// Elements arrive in row-major order, one beat per start pulse taken while
// busy is low. The beat that completes the matrix (row_count times
// column_count elements, with a size of zero used as one and a size above
// MAX_ROWS or MAX_COLS used as that maximum) starts the emission pass: busy
// stays high while the pass runs, and the element buffer has a single read
// port and is read once per result. Each result appears on rsp_out_value
// with a one-cycle rsp_valid strobe in the cycle after its buffer read. The
// receiver cannot stall the block and must take every strobe. The final
// result of each matrix carries rsp_out_last. It appears in the first cycle
// in which busy is low again, and a new element may be taken in that same
// cycle. The size registers are written through the csr port and must only
// change while no results are outstanding.
// ----------------------------------------------------------------------------
module matrix_diagonal_zigzag_reorder_top #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [mdzr_pkg::VALUE_W-1:0]  req_element_value,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mdzr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mdzr_pkg::DIM_W-1:0]           csr_write_data,
   output logic                                      rsp_valid,
   output logic signed [mdzr_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic                                      rsp_out_last
);

   import mdzr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller decides when to load and when to step the walk.
   mdzr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .status(status),
      .cmd   (cmd)
   );

   // The datapath owns the buffer, the counters and the result strobe.
   mdzr_datapath #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_element_value(req_element_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_last     (rsp_out_last)
   );

   // Every buffer read during emission must produce a result beat next cycle.
   a_step_gives_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.step_en |=> rsp_valid)
      else $error("emission read did not produce a result beat");

   // The final beat of a matrix arrives only after the emission pass ended.
   a_last_after_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_last) |-> !busy)
      else $error("last beat seen while emission still running");

   // The element that completes a matrix must start the emission pass.
   a_full_starts_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && status.load_done) |=> busy)
      else $error("completed matrix did not start emission");

   // Loading and emission never happen in the same cycle.
   a_no_load_in_pass: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_en && cmd.step_en))
      else $error("load and emission step overlap");

endmodule
`default_nettype wire

[hw/rtl/mdzr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mdzr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/mdzr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix diagonal zigzag reorder controller
// Sequences loading of elements and the emission pass over the buffer.
// ----------------------------------------------------------------------------
module mdzr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire mdzr_pkg::status_type status,
   output mdzr_pkg::cmd_type        cmd
);

   import mdzr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_en = 1'b1;
               if (status.load_done) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            busy        = 1'b1;
            cmd.step_en = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/mdzr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix diagonal zigzag reorder datapath
// Holds the size registers, load counter, element buffer, diagonal walk
// counters and the result strobe.
// ----------------------------------------------------------------------------
module mdzr_datapath #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mdzr_pkg::cmd_type                    cmd,
   output mdzr_pkg::status_type                      status,
   input  wire logic signed [mdzr_pkg::VALUE_W-1:0]  req_element_value,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mdzr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mdzr_pkg::DIM_W-1:0]           csr_write_data,
   output logic                                      rsp_valid,
   output logic signed [mdzr_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic                                      rsp_out_last
);

   import mdzr_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SW    = $clog2(MAX_ROWS + MAX_COLS + 1);
   localparam int PW    = 2 * SW;

   // Lowest and highest row on anti-diagonal x.
   function automatic logic [SW-1:0] diag_lo(input logic [SW-1:0] x,
                                             input logic [SW-1:0] nc);
      logic [SW-1:0] xp;
      xp = x + SW'(1);
      return (xp > nc) ? (xp - nc) : '0;
   endfunction

   function automatic logic [SW-1:0] diag_hi(input logic [SW-1:0] x,
                                             input logic [SW-1:0] nr);
      logic [SW-1:0] top;
      top = nr - SW'(1);
      return (x < top) ? x : top;
   endfunction

   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [CNT_W-1:0] loaded_ff, loaded_in;
   logic [SW-1:0]    diag_ff, diag_in;
   logic [SW-1:0]    row_ff, row_in;
   logic             valid_ff, valid_in;
   logic             last_ff, last_in;

   logic [SW-1:0]    rows, cols;
   logic [PW-1:0]    total;
   logic [AW-1:0]    pos;
   logic [SW-1:0]    lo, hi, diag_next, col;
   logic             end_diag;
   logic [PW-1:0]    addr_wide;
   logic [AW-1:0]    rd_addr;
   logic [VALUE_W-1:0] rd_data;

   // Clamp the size registers and the load position into the legal range.
   always_comb begin
      if (rows_ff == '0) begin
         rows = SW'(1);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         rows = SW'(MAX_ROWS);
      end else begin
         rows = SW'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols = SW'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         cols = SW'(MAX_COLS);
      end else begin
         cols = SW'(cols_ff);
      end
      total = PW'(rows) * PW'(cols);
      if (32'(loaded_ff) >= 32'(DEPTH)) begin
         pos = AW'(DEPTH - 1);
      end else begin
         pos = AW'(loaded_ff);
      end
   end

   // Diagonal walk.
   always_comb begin
      lo        = diag_lo(diag_ff, cols);
      hi        = diag_hi(diag_ff, rows);
      end_diag  = diag_ff[0] ? (row_ff == hi) : (row_ff == lo);
      diag_next = diag_ff + SW'(1);
      col       = diag_ff - row_ff;
      addr_wide = PW'(row_ff) * PW'(cols) + PW'(col);
      rd_addr   = AW'(addr_wide);

      status.load_done = (32'(pos) + 32'd1) >= 32'(total);
      status.emit_last = end_diag && (diag_ff == (rows + cols - SW'(2)));
   end

   always_comb begin
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      loaded_in = loaded_ff;
      diag_in   = diag_ff;
      row_in    = row_ff;
      valid_in  = cmd.step_en;
      last_in   = cmd.step_en && status.emit_last;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_COUNT:    rows_in = csr_write_data;
            CSR_COLUMN_COUNT: cols_in = csr_write_data;
            default: ;
         endcase
      end

      if (cmd.load_en) begin
         if (status.load_done) begin
            loaded_in = '0;
            diag_in   = '0;
            row_in    = '0;
         end else begin
            loaded_in = CNT_W'(pos) + CNT_W'(1);
         end
      end

      if (cmd.step_en) begin
         if (end_diag) begin
            diag_in = diag_next;
            row_in  = diag_next[0] ? diag_lo(diag_next, cols) : diag_hi(diag_next, rows);
         end else if (diag_ff[0]) begin
            row_in = row_ff + SW'(1);
         end else begin
            row_in = row_ff - SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= DIM_RESET;
         cols_ff   <= DIM_RESET;
         loaded_ff <= '0;
         diag_ff   <= '0;
         row_ff    <= '0;
         valid_ff  <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         loaded_ff <= loaded_in;
         diag_ff   <= diag_in;
         row_ff    <= row_in;
         valid_ff  <= valid_in;
         last_ff   <= last_in;
      end
   end

   mdzr_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (cmd.load_en),
      .wr_addr   (pos),
      .wr_data   (req_element_value),
      .rd_en     (cmd.step_en),
      .rd_addr   (rd_addr),
      .rd_data_ff(rd_data)
   );

   assign rsp_valid     = valid_ff;
   assign rsp_out_last  = last_ff;
   assign rsp_out_value = signed'(rd_data);

endmodule
`default_nettype wire
